// ----- design/mhpq_pkg.sv -----
// Shared constants, types and codes for the min-heap priority queue.
`default_nettype none

package mhpq_pkg;

    localparam int HEAP_DEPTH = 128;
    localparam int KEY_WIDTH  = 16;

    localparam int KEY_PORT_W = 16;
    localparam int PAY_W      = 12;
    localparam int COUNT_W    = 8;

    localparam int ADDR_W = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int OCC_W  = $clog2(HEAP_DEPTH + 1);
    // child indexes reach 2*HEAP_DEPTH; one spare bit keeps compares unsigned-safe
    localparam int IDX_W  = ADDR_W + 2;

    typedef logic [KEY_WIDTH-1:0] t_key;
    typedef logic [PAY_W-1:0]     t_pay;
    typedef logic [ADDR_W-1:0]    t_addr;
    typedef logic [OCC_W-1:0]     t_occ;

    typedef struct packed {
        t_key key;
        t_pay pay;
    } t_entry;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_command;

    // Controller to datapath.
    typedef struct packed {
        logic    latch_in;     // take the new entry as the moving entry, pos = occupancy
        logic    st_load;      // load result status, clear result key and payload
        t_status st_val;
        logic    rd_top;       // read root and last slot
        logic    rd_down;      // read both children of pos (else parent of pos)
        logic    take_root;    // root to result, last to moving entry, pos = 0
        logic    move_parent;  // parent down into pos, climb
        logic    move_child;   // smaller child up into pos, descend
        logic    place;        // write the moving entry at pos
        logic    inc_occ;
        logic    out_load;     // copy the result into the output register
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic at_root;
        logic has_child;
        logic up_swap;
        logic down_swap;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- design/mhpq_dp.sv -----
// Datapath: entry memory, moving entry, position and occupancy, result register.
`default_nettype none

module mhpq_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire mhpq_pkg::t_dp_cmd              i_cmd,
    output mhpq_pkg::t_dp_stat                  o_stat,
    input  wire logic [mhpq_pkg::KEY_PORT_W-1:0] i_key_in,
    input  wire logic [mhpq_pkg::PAY_W-1:0]      i_payload_in,
    output logic [1:0]                          o_status,
    output logic [mhpq_pkg::KEY_PORT_W-1:0]      o_key_out,
    output logic [mhpq_pkg::PAY_W-1:0]           o_payload_out,
    output logic [mhpq_pkg::COUNT_W-1:0]         o_entry_count
);
    import mhpq_pkg::*;

    t_entry r_mem [HEAP_DEPTH];
    t_entry r_rd0, r_rd1;
    t_entry r_cur, n_cur;
    t_addr  r_pos, n_pos;
    t_occ   r_occ, n_occ;
    t_status r_res_st;
    t_entry  r_res;
    t_status r_out_st;
    t_entry  r_out;
    t_occ    r_out_occ;

    logic [IDX_W-1:0] w_cl, w_cr, w_occ_x;
    logic             w_has_right, w_take_right;
    t_addr            w_parent, w_last, w_addr0, w_addr1, w_child_addr;
    t_entry           w_child, w_wdata;
    logic             w_wen;

    assign w_cl         = {1'b0, r_pos, 1'b1};
    assign w_cr         = w_cl + IDX_W'(1);
    assign w_occ_x      = IDX_W'(r_occ);
    assign w_has_right  = w_cr < w_occ_x;
    assign w_parent     = (r_pos - ADDR_W'(1)) >> 1;
    assign w_last       = ADDR_W'(r_occ - OCC_W'(1));
    assign w_take_right = w_has_right && (r_rd0.key > r_rd1.key);
    assign w_child      = w_take_right ? r_rd1 : r_rd0;
    assign w_child_addr = w_take_right ? w_cr[ADDR_W-1:0] : w_cl[ADDR_W-1:0];

    always_comb begin
        if (i_cmd.rd_top) begin
            w_addr0 = '0;
            w_addr1 = w_last;
        end else if (i_cmd.rd_down) begin
            w_addr0 = w_cl[ADDR_W-1:0];
            w_addr1 = w_cr[ADDR_W-1:0];
        end else begin
            w_addr0 = w_parent;
            w_addr1 = w_last;
        end
    end

    always_comb begin
        w_wen   = i_cmd.move_parent | i_cmd.move_child | i_cmd.place;
        w_wdata = r_cur;
        if (i_cmd.move_parent) begin
            w_wdata = r_rd0;
        end else if (i_cmd.move_child) begin
            w_wdata = w_child;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wen) begin
            r_mem[r_pos] <= w_wdata;
        end
        r_rd0 <= r_mem[w_addr0];
        r_rd1 <= r_mem[w_addr1];
    end

    always_comb begin
        n_cur = r_cur;
        n_pos = r_pos;
        n_occ = r_occ;
        if (i_cmd.latch_in) begin
            n_cur.key = KEY_WIDTH'(i_key_in);
            n_cur.pay = i_payload_in;
            n_pos     = ADDR_W'(r_occ);
        end
        if (i_cmd.take_root) begin
            n_cur = r_rd1;
            n_pos = '0;
            n_occ = r_occ - OCC_W'(1);
        end
        if (i_cmd.move_parent) begin
            n_pos = w_parent;
        end
        if (i_cmd.move_child) begin
            n_pos = w_child_addr;
        end
        if (i_cmd.inc_occ) begin
            n_occ = r_occ + OCC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_pos <= n_pos;
        if (i_cmd.st_load) begin
            r_res_st <= i_cmd.st_val;
            r_res    <= '0;
        end else if (i_cmd.take_root) begin
            r_res <= r_rd0;
        end
        if (i_cmd.out_load) begin
            r_out_st  <= r_res_st;
            r_out     <= r_res;
            r_out_occ <= r_occ;
        end
    end

    assign o_stat.full      = r_occ >= OCC_W'(HEAP_DEPTH);
    assign o_stat.empty     = r_occ == '0;
    assign o_stat.at_root   = r_pos == '0;
    assign o_stat.has_child = w_cl < w_occ_x;
    assign o_stat.up_swap   = r_rd0.key > r_cur.key;
    assign o_stat.down_swap = r_cur.key > w_child.key;

    assign o_status      = r_out_st;
    assign o_key_out     = KEY_PORT_W'(r_out.key);
    assign o_payload_out = r_out.pay;
    assign o_entry_count = COUNT_W'(r_out_occ);

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(HEAP_DEPTH))
        else $error("occupancy above heap depth");

    a_inc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.inc_occ |=> r_occ == $past(r_occ) + OCC_W'(1))
        else $error("insert did not grow occupancy by one");

    a_take_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_root |-> r_occ != '0)
        else $error("removal work on an empty heap");

    a_one_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.move_parent, i_cmd.move_child, i_cmd.place}))
        else $error("more than one write source selected");

endmodule

`default_nettype wire

// ----- design/mhpq_ctrl.sv -----
// Controller: sequences insert sift-up and remove sift-down, owns the result valid.
`default_nettype none

module mhpq_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_command,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    input  wire mhpq_pkg::t_dp_stat i_stat,
    output mhpq_pkg::t_dp_cmd       o_cmd
);
    import mhpq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_DEL_TAKE,
        S_DN_CHK,
        S_DN_CMP,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   w_accept;

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                // the read of root and last runs every idle cycle for a removal
                o_cmd.rd_top = 1'b1;
                if (w_accept) begin
                    o_cmd.st_load = 1'b1;
                    if (t_command'(i_command) == CMD_INSERT) begin
                        if (i_stat.full) begin
                            o_cmd.st_val = ST_FULL;
                            n_state      = S_FIN;
                        end else begin
                            o_cmd.st_val   = ST_DONE;
                            o_cmd.latch_in = 1'b1;
                            n_state        = S_UP_CHK;
                        end
                    end else begin
                        if (i_stat.empty) begin
                            o_cmd.st_val = ST_EMPTY;
                            n_state      = S_FIN;
                        end else begin
                            o_cmd.st_val = ST_DONE;
                            n_state      = S_DEL_TAKE;
                        end
                    end
                end
            end
            S_UP_CHK: begin
                if (i_stat.at_root) begin
                    o_cmd.place   = 1'b1;
                    o_cmd.inc_occ = 1'b1;
                    n_state       = S_FIN;
                end else begin
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_stat.up_swap) begin
                    o_cmd.move_parent = 1'b1;
                    n_state           = S_UP_CHK;
                end else begin
                    o_cmd.place   = 1'b1;
                    o_cmd.inc_occ = 1'b1;
                    n_state       = S_FIN;
                end
            end
            S_DEL_TAKE: begin
                o_cmd.take_root = 1'b1;
                n_state         = S_DN_CHK;
            end
            S_DN_CHK: begin
                o_cmd.rd_down = 1'b1;
                if (i_stat.has_child) begin
                    n_state = S_DN_CMP;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state     = S_FIN;
                end
            end
            S_DN_CMP: begin
                o_cmd.rd_down = 1'b1;
                if (i_stat.down_swap) begin
                    o_cmd.move_child = 1'b1;
                    n_state          = S_DN_CHK;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state     = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_out_valid && !i_out_ready) |=> r_state == S_FIN)
        else $error("result dropped while output slot busy");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_out_valid && r_state == S_IDLE)
        else $error("result load did not raise valid");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != S_IDLE)
        else $error("accepted transaction did not start work");

endmodule

`default_nettype wire

// ----- design/min_heap_priority_queue.sv -----
// Top level of the binary min-heap priority queue.
// A binary min-heap of up to HEAP_DEPTH (key, payload) entries ordered on the key.
// Command 0 inserts an entry: it goes to the first free slot and climbs while its
// parent key is strictly greater. Command 1 removes the minimum: the root is returned,
// the last entry moves to the root and sinks, taking the left child on a tie and
// stopping when it is less than or equal to the smaller child. Each input transaction
// yields exactly one result transaction carrying a status (done, rejected full,
// rejected empty), the removed key and payload (zero otherwise) and the entry count
// after the operation. One transaction is worked at a time. An entry moves at most
// log2(HEAP_DEPTH) levels, so up to 7 at depth 128; a rejected command goes straight
// to the result step. Each level costs one memory read, registered, and one
// compare-and-write through the single write port of the entry memory. A finished
// result sits in an output register, so the next command is taken while the result
// still waits. The entry memory needs no clearing after reset: slots at or above the
// entry count are never used.
`default_nettype none

module min_heap_priority_queue (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // command channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic                            i_command,
    input  wire logic [mhpq_pkg::KEY_PORT_W-1:0] i_key_in,
    input  wire logic [mhpq_pkg::PAY_W-1:0]      i_payload_in,
    // result channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [1:0]                           o_status,
    output logic [mhpq_pkg::KEY_PORT_W-1:0]      o_key_out,
    output logic [mhpq_pkg::PAY_W-1:0]           o_payload_out,
    output logic [mhpq_pkg::COUNT_W-1:0]         o_entry_count
);
    import mhpq_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequence the sift steps and hold the result valid.
    mhpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Hold the entries, the moving entry and the result.
    mhpq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_key_in      (i_key_in),
        .i_payload_in  (i_payload_in),
        .o_status      (o_status),
        .o_key_out     (o_key_out),
        .o_payload_out (o_payload_out),
        .o_entry_count (o_entry_count)
    );

endmodule

`default_nettype wire
